// ===== hdl/mbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared types, codes and helpers of the Moore-neighbor boundary tracer.
// ----------------------------------------------------------------------------
package mbt_pkg;

  // Field widths
  localparam int POS_W      = 6;   // row / column of a pixel
  localparam int POS_LIMIT  = 64;  // positions a 6-bit field can reach
  localparam int AREA_W     = 7;   // row / column counts, 0..64 and beyond
  localparam int LEVEL_W    = 8;
  localparam int DIR_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND_LEVEL = 2'd2;

  // Configuration reset values
  localparam logic [AREA_W-1:0]  IMAGE_ROWS_RST       = 7'd64;
  localparam logic [AREA_W-1:0]  IMAGE_COLS_RST       = 7'd64;
  localparam logic [LEVEL_W-1:0] FOREGROUND_LEVEL_RST = 8'd255;

  // Direction codes, rows grow southward, columns eastward
  localparam logic [DIR_W-1:0] DIR_S    = 3'd0;  // (+1, 0)
  localparam logic [DIR_W-1:0] DIR_SW   = 3'd1;  // (+1,-1)
  localparam logic [DIR_W-1:0] DIR_WEST = 3'd2;  // ( 0,-1)
  localparam logic [DIR_W-1:0] DIR_NW   = 3'd3;  // (-1,-1)
  localparam logic [DIR_W-1:0] DIR_N    = 3'd4;  // (-1, 0)
  localparam logic [DIR_W-1:0] DIR_NE   = 3'd5;  // (-1,+1)
  localparam logic [DIR_W-1:0] DIR_E    = 3'd6;  // ( 0,+1)
  localparam logic [DIR_W-1:0] DIR_SE   = 3'd7;  // (+1,+1)
  localparam logic [DIR_W-1:0] DIR_START = DIR_SE;

  // Request and result payloads
  typedef struct packed {
    logic               operation;
    logic [POS_W-1:0]   pixel_row;
    logic [POS_W-1:0]   pixel_col;
    logic [LEVEL_W-1:0] pixel_level;
  } mbt_req_t;

  typedef struct packed {
    logic             point_valid;
    logic [POS_W-1:0] point_row;
    logic [POS_W-1:0] point_col;
    logic             closes_contour;
  } mbt_res_t;

  localparam mbt_res_t NO_POINT = '{point_valid: 1'b0, point_row: '0,
                                    point_col: '0, closes_contour: 1'b1};

  // Outcome of one neighbor search
  typedef struct packed {
    logic             found;
    logic [DIR_W-1:0] dir;
  } nbr_hit_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

  // One move in a direction, wrapping in 6 bits
  function automatic pos_t step_pos(input pos_t p, input logic [DIR_W-1:0] d);
    pos_t q;
    q = p;
    case (d)
      DIR_S:    begin q.row = p.row + 1'b1; end
      DIR_SW:   begin q.row = p.row + 1'b1; q.col = p.col - 1'b1; end
      DIR_WEST: begin q.col = p.col - 1'b1; end
      DIR_NW:   begin q.row = p.row - 1'b1; q.col = p.col - 1'b1; end
      DIR_N:    begin q.row = p.row - 1'b1; end
      DIR_NE:   begin q.row = p.row - 1'b1; q.col = p.col + 1'b1; end
      DIR_E:    begin q.col = p.col + 1'b1; end
      DIR_SE:   begin q.row = p.row + 1'b1; q.col = p.col + 1'b1; end
      default: begin q = p; end
    endcase
    return q;
  endfunction

endpackage

// ===== hdl/mbt_row_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_row_mem
// Bit image store, one image row per word, bit-masked write, registered read.
// ----------------------------------------------------------------------------
module mbt_row_mem #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_mask,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write only the masked bits of the addressed row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wr_mask[i]) begin
          mem[wr_addr][i] <= wr_data[i];
        end
      end
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/mbt_nbr_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_nbr_search
// Finds the next contour neighbor in a 3x3 window, rotating from the
// start direction that the last move sets.
// ----------------------------------------------------------------------------
module mbt_nbr_search (
  input  logic [2:0][2:0]             window,   // [row above..below][col left..right]
  input  logic [mbt_pkg::DIR_W-1:0]   last_dir,
  output mbt_pkg::nbr_hit_t           hit
);
  import mbt_pkg::*;

  logic [7:0]       nbr;
  logic [DIR_W-1:0] first;

  // Neighbor bits indexed by direction code
  always_comb begin
    nbr = '0;
    nbr[DIR_S]    = window[2][1];
    nbr[DIR_SW]   = window[2][0];
    nbr[DIR_WEST] = window[1][0];
    nbr[DIR_NW]   = window[0][0];
    nbr[DIR_N]    = window[0][1];
    nbr[DIR_NE]   = window[0][2];
    nbr[DIR_E]    = window[1][2];
    nbr[DIR_SE]   = window[2][2];
  end

  // Odd direction backs off two steps, even one
  assign first = last_dir[0] ? (last_dir + 3'd6) : (last_dir + 3'd7);

  // First set neighbor going up from the start direction
  always_comb begin
    logic [DIR_W-1:0] d;
    hit = '0;
    for (int k = 7; k >= 0; k--) begin
      d = first + DIR_W'(k);
      if (nbr[d]) begin
        hit.found = 1'b1;
        hit.dir   = d;
      end
    end
  end

endmodule

// ===== hdl/moore_boundary_tracer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moore_boundary_tracer_top
// 8-connected outer contour tracer over a bit image held in a row memory.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; results appear for
// one cycle with done high and cannot be held off. A load request writes one
// pixel and gives no result, and busy stays low. A step request gives one
// result: when the trace is running it fetches three rows through the single
// read port, searches the window and registers the result; the first step
// after a load also scans the image row by row until the first object row,
// or to the end of the area in use; a step after the trace has finished
// answers from idle with an empty result. After reset the image store is
// cleared one row per cycle, all min(MAX_ROWS, 64) rows, with busy high;
// configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module moore_boundary_tracer_top #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  mbt_pkg::mbt_req_t              request,
  output logic                           done,
  output mbt_pkg::mbt_res_t              result,
  input  logic                           cfg_we,
  input  logic [mbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mbt_pkg::*;

  localparam int RU     = (MAX_ROWS < POS_LIMIT) ? MAX_ROWS : POS_LIMIT;
  localparam int CU     = (MAX_COLS < POS_LIMIT) ? MAX_COLS : POS_LIMIT;
  localparam int ROW_AW = $clog2(RU);
  localparam int COL_AW = $clog2(CU);
  localparam logic [AREA_W-1:0] RU_N = AREA_W'(RU);
  localparam logic [AREA_W-1:0] CU_N = AREA_W'(CU);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_NBR   = 5'b01000,
    ST_EVAL  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TRACE = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  state_t state, state_next;
  phase_t phase;

  logic [AREA_W-1:0]  image_rows, image_cols;
  logic [LEVEL_W-1:0] foreground_level;
  logic [AREA_W-1:0]  area_rows, area_cols;

  pos_t              cur, start_pos;
  logic [DIR_W-1:0]  last_dir;
  logic [ROW_AW-1:0] clr_row;
  logic [AREA_W-1:0] scan_row;
  logic              pend_ok;
  logic [POS_W-1:0]  pend_row;
  logic [1:0]        nb_k;
  logic [2:0][2:0]   win;

  logic              accept, is_load, load_ok;
  logic              scan_live, row_hit;
  logic [CU-1:0]     col_mask, scan_bits;
  logic [POS_W-1:0]  first_col;
  logic [AREA_W-1:0] nb_row;
  logic              nb_row_ok;
  logic [2:0]        taps;
  nbr_hit_t          hit;
  pos_t              next_pos;

  logic              mem_we, mem_re;
  logic [ROW_AW-1:0] mem_waddr, mem_raddr;
  logic [CU-1:0]     mem_wmask, mem_wdata, mem_rdata;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign is_load = (request.operation == OP_LOAD);
  assign load_ok = (int'(request.pixel_row) < RU) && (int'(request.pixel_col) < CU);

  // Area in use
  assign area_rows = (image_rows < RU_N) ? image_rows : RU_N;
  assign area_cols = (image_cols < CU_N) ? image_cols : CU_N;

  always_comb begin
    for (int i = 0; i < CU; i++) begin
      col_mask[i] = (AREA_W'(i) < area_cols);
    end
  end

  // Raster scan: first object column of the row just read
  assign scan_live = (scan_row < area_rows);
  assign scan_bits = mem_rdata & col_mask;
  assign row_hit   = |scan_bits;

  always_comb begin
    first_col = '0;
    for (int i = CU - 1; i >= 0; i--) begin
      if (scan_bits[i]) begin
        first_col = POS_W'(i);
      end
    end
  end

  // Neighbor rows: above, current, below; off-area rows read as background
  assign nb_row    = {1'b0, cur.row} + AREA_W'(nb_k) - AREA_W'(1);
  assign nb_row_ok = (nb_row < area_rows);

  always_comb begin
    logic [AREA_W-1:0] tc;
    taps = '0;
    for (int j = 0; j < 3; j++) begin
      tc = {1'b0, cur.col} + AREA_W'(j) - AREA_W'(1);
      if (tc < area_cols) begin
        taps[j] = mem_rdata[tc[COL_AW-1:0]];
      end
    end
  end

  mbt_nbr_search u_search (
    .window   (win),
    .last_dir (last_dir),
    .hit      (hit)
  );

  assign next_pos = step_pos(cur, hit.dir);

  // Memory port control; writes happen only in clear and idle, reads only
  // in scan and neighbor fetch, so a row is never read and written together
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = request.pixel_row[ROW_AW-1:0];
    mem_wmask = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row;
        mem_wmask = '1;
      end
      ST_IDLE: begin
        if (accept && is_load && load_ok) begin
          mem_we    = 1'b1;
          mem_wmask = CU'(1) << request.pixel_col;
          mem_wdata = {CU{request.pixel_level == foreground_level}};
        end
      end
      ST_SCAN: begin
        mem_re    = scan_live;
        mem_raddr = scan_row[ROW_AW-1:0];
      end
      ST_NBR: begin
        mem_re    = (nb_k != 2'd3) && nb_row_ok;
        mem_raddr = nb_row[ROW_AW-1:0];
      end
      default: begin
      end
    endcase
  end

  mbt_row_mem #(
    .DEPTH (RU),
    .WIDTH (CU)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_mask (mem_wmask),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_row == ROW_AW'(RU - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && !is_load) begin
          if (phase == PH_IDLE)       state_next = ST_SCAN;
          else if (phase == PH_TRACE) state_next = ST_NBR;
        end
      end
      ST_SCAN: begin
        if (pend_ok && row_hit)         state_next = ST_NBR;
        else if (!pend_ok && !scan_live) state_next = ST_IDLE;
      end
      ST_NBR: begin
        if (nb_k == 2'd3) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows       <= IMAGE_ROWS_RST;
      image_cols       <= IMAGE_COLS_RST;
      foreground_level <= FOREGROUND_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_ROWS:       image_rows       <= cfg_data[AREA_W-1:0];
        CFG_IMAGE_COLS:       image_cols       <= cfg_data[AREA_W-1:0];
        CFG_FOREGROUND_LEVEL: foreground_level <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Window capture, payload only
  always_ff @(posedge clk) begin
    if (state == ST_NBR && nb_k != 2'd0) begin
      win[nb_k - 2'd1] <= pend_ok ? taps : 3'b000;
    end
  end

  // Trace state and results
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      phase     <= PH_IDLE;
      cur       <= '0;
      start_pos <= '0;
      last_dir  <= DIR_START;
      clr_row   <= '0;
      scan_row  <= '0;
      pend_ok   <= 1'b0;
      nb_k      <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            if (is_load) begin
              phase    <= PH_IDLE;
              last_dir <= DIR_START;
            end else begin
              case (phase)
                PH_IDLE: begin
                  scan_row <= '0;
                  pend_ok  <= 1'b0;
                end
                PH_TRACE: begin
                  nb_k <= '0;
                end
                default: begin
                  result <= NO_POINT;
                  done   <= 1'b1;
                end
              endcase
            end
          end
        end
        ST_SCAN: begin
          if (scan_live) scan_row <= scan_row + 1'b1;
          pend_ok  <= scan_live;
          pend_row <= scan_row[POS_W-1:0];
          if (pend_ok && row_hit) begin
            start_pos <= '{row: pend_row, col: first_col};
            cur       <= '{row: pend_row, col: first_col};
            last_dir  <= DIR_START;
            phase     <= PH_TRACE;
            nb_k      <= '0;
          end else if (!pend_ok && !scan_live) begin
            phase  <= PH_DONE;
            result <= NO_POINT;
            done   <= 1'b1;
          end
        end
        ST_NBR: begin
          nb_k    <= nb_k + 1'b1;
          pend_ok <= nb_row_ok;
        end
        ST_EVAL: begin
          done               <= 1'b1;
          result.point_valid <= 1'b1;
          result.point_row   <= cur.row;
          result.point_col   <= cur.col;
          if (!hit.found) begin
            // isolated pixel closes at once
            result.closes_contour <= 1'b1;
            phase                 <= PH_DONE;
          end else begin
            result.closes_contour <= (next_pos == start_pos);
            if (next_pos == start_pos) phase <= PH_DONE;
            cur      <= next_pos;
            last_dir <= hit.dir;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Checks
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && is_load) |=> !done)
    else $error("load request produced a result");

  a_mem_port_split: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("image row read and written in the same cycle");

  a_empty_closes: assert property (@(posedge clk) disable iff (rst)
    (done && !result.point_valid) |-> (result.closes_contour &&
                                        result.point_row == '0 &&
                                        result.point_col == '0))
    else $error("empty result not marked as closing");

  a_eval_after_fetch: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> ($past(state) == ST_NBR && $past(nb_k) == 2'd3))
    else $error("search evaluated before the window was complete");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a request is still in work");

endmodule

// ===== bench/mbt_contour_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_contour_checker
// Watches the request, result and register ports of the boundary tracer, keeps
// its own copy of the bit image and trace state, predicts each contour point
// and compares every result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mbt_contour_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  mbt_pkg::mbt_req_t              request,
  input  logic                           done,
  input  mbt_pkg::mbt_res_t              result,
  input  logic                           cfg_we,
  input  logic [mbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             pending,
  output int                             errors
);
  import mbt_pkg::*;

  localparam int IMG_DIM = 64;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_RUN,
    WALK_DONE
  } walk_phase_t;

  // Shadow registers and image
  logic [AREA_W-1:0]  rows_used;
  logic [AREA_W-1:0]  cols_used;
  logic [LEVEL_W-1:0] object_level;
  bit                 image_bits [0:IMG_DIM-1][0:IMG_DIM-1];

  // Walk state
  walk_phase_t        walk_phase;
  int                 here_r, here_c;
  int                 origin_r, origin_c;
  logic [DIR_W-1:0]   heading;

  mbt_res_t           contour_q [$];
  mbt_res_t           oldest;

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t ns: contour point %s mismatch, got %0d want %0d",
             $time, what, got, want);
  endtask

  function automatic int span_rows();
    return (rows_used > IMG_DIM) ? IMG_DIM : int'(rows_used);
  endfunction

  function automatic int span_cols();
    return (cols_used > IMG_DIM) ? IMG_DIM : int'(cols_used);
  endfunction

  // Pixels outside the area in use are background
  function automatic bit pixel_set(input int r, input int c);
    if (r < 0 || c < 0 || r >= span_rows() || c >= span_cols()) return 1'b0;
    return image_bits[r][c];
  endfunction

  function automatic void heading_offset(input logic [DIR_W-1:0] d,
                                         output int dr, output int dc);
    dr = 0;
    dc = 0;
    case (d)
      DIR_S:    begin dr =  1; end
      DIR_SW:   begin dr =  1; dc = -1; end
      DIR_WEST: begin dc = -1; end
      DIR_NW:   begin dr = -1; dc = -1; end
      DIR_N:    begin dr = -1; end
      DIR_NE:   begin dr = -1; dc =  1; end
      DIR_E:    begin dc =  1; end
      DIR_SE:   begin dr =  1; dc =  1; end
      default: begin dr = 0; dc = 0; end
    endcase
  endfunction

  // A load sets or clears one bit and restarts the walk
  function automatic void store_pixel(input mbt_req_t req);
    image_bits[req.pixel_row][req.pixel_col] = (req.pixel_level == object_level);
    walk_phase = WALK_IDLE;
    heading    = DIR_START;
  endfunction

  // Next point of the outer contour, advancing the walk
  function automatic mbt_res_t next_contour_point();
    mbt_res_t         res;
    bit               found;
    bit               hit;
    int               r, c, k, dr, dc, nr, nc;
    logic [DIR_W-1:0] first, d;
    res = '{point_valid: 1'b0, point_row: '0, point_col: '0, closes_contour: 1'b1};
    nr  = 0;
    nc  = 0;
    d   = DIR_START;
    // First step after a load: raster scan for the start pixel
    if (walk_phase == WALK_IDLE) begin
      found = 1'b0;
      for (r = 0; r < span_rows() && !found; r++) begin
        for (c = 0; c < span_cols() && !found; c++) begin
          if (pixel_set(r, c)) begin
            origin_r = r;
            origin_c = c;
            found    = 1'b1;
          end
        end
      end
      if (!found) begin
        walk_phase = WALK_DONE;
        return res;
      end
      here_r     = origin_r;
      here_c     = origin_c;
      heading    = DIR_START;
      walk_phase = WALK_RUN;
    end
    if (walk_phase != WALK_RUN) return res;

    // Search starts back from where we came, odd headings one further
    first = heading[0] ? heading + 3'd6 : heading + 3'd7;
    hit   = 1'b0;
    for (k = 0; k < 8 && !hit; k++) begin
      d = first + k[DIR_W-1:0];
      heading_offset(d, dr, dc);
      nr = here_r + dr;
      nc = here_c + dc;
      if (pixel_set(nr, nc)) hit = 1'b1;
    end

    res.point_valid = 1'b1;
    res.point_row   = here_r[POS_W-1:0];
    res.point_col   = here_c[POS_W-1:0];
    if (!hit) begin
      // isolated pixel: closes at once
      res.closes_contour = 1'b1;
      walk_phase         = WALK_DONE;
      return res;
    end
    res.closes_contour = (nr == origin_r && nc == origin_c);
    if (res.closes_contour) walk_phase = WALK_DONE;
    here_r  = nr & (IMG_DIM - 1);
    here_c  = nc & (IMG_DIM - 1);
    heading = d;
    return res;
  endfunction

  // Compare results, then predict from accepted requests and register writes
  always @(posedge clk) begin
    if (rst) begin
      rows_used    = IMAGE_ROWS_RST;
      cols_used    = IMAGE_COLS_RST;
      object_level = FOREGROUND_LEVEL_RST;
      for (int r = 0; r < IMG_DIM; r++)
        for (int c = 0; c < IMG_DIM; c++)
          image_bits[r][c] = 1'b0;
      walk_phase = WALK_IDLE;
      here_r     = 0;
      here_c     = 0;
      origin_r   = 0;
      origin_c   = 0;
      heading    = DIR_START;
      contour_q.delete();
    end else begin
      if (done) begin
        if (contour_q.size() == 0) begin
          report_mismatch("unrequested result", 1, 0);
        end else begin
          oldest = contour_q.pop_front();
          if (result.point_valid !== oldest.point_valid)
            report_mismatch("point_valid", int'(result.point_valid),
                            int'(oldest.point_valid));
          if (result.point_row !== oldest.point_row)
            report_mismatch("point_row", int'(result.point_row),
                            int'(oldest.point_row));
          if (result.point_col !== oldest.point_col)
            report_mismatch("point_col", int'(result.point_col),
                            int'(oldest.point_col));
          if (result.closes_contour !== oldest.closes_contour)
            report_mismatch("closes_contour", int'(result.closes_contour),
                            int'(oldest.closes_contour));
        end
      end
      if (start && !busy) begin
        if (request.operation == OP_LOAD) store_pixel(request);
        else contour_q.insert(contour_q.size(), next_contour_point());
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_ROWS:       rows_used    = cfg_data[AREA_W-1:0];
          CFG_IMAGE_COLS:       cols_used    = cfg_data[AREA_W-1:0];
          CFG_FOREGROUND_LEVEL: object_level = cfg_data[LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
    pending = contour_q.size();
  end

endmodule

// ===== bench/moore_boundary_tracer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moore_boundary_tracer_top_tb
// Drives pixel loads and contour steps into the boundary tracer: a directed
// opening on image corners and small shapes, then phases of random blobs and
// walks under changing image sizes and object levels. Checking is done by
// mbt_contour_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module moore_boundary_tracer_top_tb;
  import mbt_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 6;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 16;
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 125;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  mbt_req_t              request = '0;
  logic                  done;
  mbt_res_t              result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    pending;
  int                    errors;
  int                    idle_cycles = 0;

  // Stimulus scratch
  int                    phase_no, sent, burst, walk_len;
  int                    span_r, span_c, anchor_r, anchor_c, pr, pc;
  bit                    quiet;
  logic [CFG_DATA_W-1:0] rows_val, cols_val, level_val;
  logic [LEVEL_W-1:0]    lvl;

  always #CLK_HALF clk = ~clk;

  moore_boundary_tracer_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbt_contour_checker chk (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  // Watchdog: too long without an accepted request or result
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic mbt_req_t load_req(input int r, input int c,
                                        input logic [LEVEL_W-1:0] level);
    mbt_req_t req;
    req.operation   = OP_LOAD;
    req.pixel_row   = r[POS_W-1:0];
    req.pixel_col   = c[POS_W-1:0];
    req.pixel_level = level;
    return req;
  endfunction

  // Step request; the pixel fields are don't-care and get random values
  function automatic mbt_req_t step_req();
    mbt_req_t req;
    req.operation   = OP_STEP;
    req.pixel_row   = POS_W'($urandom);
    req.pixel_col   = POS_W'($urandom);
    req.pixel_level = LEVEL_W'($urandom);
    return req;
  endfunction

  // Called just after a falling edge; returns just after a falling edge once the request has been taken
  task automatic issue(input mbt_req_t req, input int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    request = req;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Wait until every step has answered and a trailing load has finished
  task automatic settle();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // Directed: empty image, then a finished trace
    issue(step_req(), 0);
    issue(step_req(), 0);
    // isolated pixel in the far corner
    issue(load_req(63, 63, 8'hFF), 1);
    issue(step_req(), 0);
    issue(step_req(), 2);
    // two pixels on the image edge, neighbors outside count as background
    issue(load_req(63, 62, 8'hFF), 0);
    repeat (3) issue(step_req(), 0);
    issue(load_req(63, 63, 8'h00), 0);
    issue(load_req(63, 62, 8'h00), 3);
    // 2x2 block at the origin
    issue(load_req(0, 0, 8'hFF), 0);
    issue(load_req(0, 1, 8'hFF), 0);
    issue(load_req(1, 0, 8'hFF), 1);
    issue(load_req(1, 1, 8'hFF), 0);
    repeat (6) issue(step_req(), 0);

    // Random phases, each under its own register setting
    for (phase_no = 0; phase_no < PHASES; phase_no++) begin
      settle();
      case (phase_no)
        0: begin rows_val = 8'd1;   cols_val = 8'd1;   level_val = 8'd0;   end
        1: begin rows_val = 8'd64;  cols_val = 8'd64;  level_val = 8'd255; end
        2: begin rows_val = 8'd0;   cols_val = 8'd64;  level_val = CFG_DATA_W'($urandom); end
        3: begin rows_val = 8'd64;  cols_val = 8'd0;   level_val = CFG_DATA_W'($urandom); end
        4: begin rows_val = 8'd200; cols_val = 8'd127; level_val = CFG_DATA_W'($urandom); end
        default: begin
          rows_val  = ($urandom_range(0, 5) == 0) ? 8'd64 : 8'($urandom_range(2, 10));
          cols_val  = ($urandom_range(0, 5) == 0) ? 8'd64 : 8'($urandom_range(2, 10));
          level_val = CFG_DATA_W'($urandom_range(0, 255));
        end
      endcase
      write_reg(CFG_IMAGE_ROWS, rows_val);
      write_reg(CFG_IMAGE_COLS, cols_val);
      write_reg(CFG_FOREGROUND_LEVEL, level_val);
      cfg_we = 1'b0;

      // area in use; an empty area still gets loads anywhere
      span_r = (rows_val[AREA_W-1:0] > 64) ? 64 : int'(rows_val[AREA_W-1:0]);
      span_c = (cols_val[AREA_W-1:0] > 64) ? 64 : int'(cols_val[AREA_W-1:0]);
      if (span_r == 0) span_r = 64;
      if (span_c == 0) span_c = 64;

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 8) begin
          // blob of loads around an anchor, then a walk over it
          anchor_r = $urandom_range(0, span_r - 1);
          anchor_c = $urandom_range(0, span_c - 1);
          burst    = $urandom_range(1, 12);
          repeat (burst) begin
            pr  = $urandom_range(anchor_r,
                                 (anchor_r + 3 < span_r) ? anchor_r + 3 : span_r - 1);
            pc  = $urandom_range(anchor_c,
                                 (anchor_c + 3 < span_c) ? anchor_c + 3 : span_c - 1);
            lvl = ($urandom_range(0, 2) != 0) ? level_val : LEVEL_W'($urandom);
            issue(load_req(pr, pc, lvl), quiet ? 0 : $urandom_range(0, 3));
          end
          walk_len = $urandom_range(1, 30);
          repeat (walk_len) issue(step_req(), quiet ? 0 : $urandom_range(0, 3));
          sent += burst + walk_len;
        end else begin
          // noise: loads anywhere and stray steps
          burst = $urandom_range(1, 8);
          repeat (burst) begin
            if ($urandom_range(0, 1) == 0)
              issue(load_req($urandom_range(0, 63), $urandom_range(0, 63),
                             LEVEL_W'($urandom)), quiet ? 0 : $urandom_range(0, 3));
            else
              issue(step_req(), quiet ? 0 : $urandom_range(0, 3));
          end
          sent += burst;
        end
      end
    end

    // Drain and verdict
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
